[rtl/sfk_pkg.sv]
// Package: shared types, constants and fixed-point helpers for the skeleton kinematics block.
package sfk_pkg;

	localparam int NUM_ANG = 9;
	localparam int CORDIC_STEPS = 16;
	localparam int NUM_POINTS = 18;

	localparam logic signed [31:0] ANG_PI = 32'sd843314857;
	localparam logic signed [31:0] ANG_HALF_PI = 32'sd421657428;
	localparam logic signed [31:0] CORDIC_K = 32'sd652032874;

	localparam logic signed [15:0] NOSE_UP = 16'sd614;
	localparam logic signed [15:0] EYE_SIDE = 16'sd328;
	localparam logic signed [15:0] EYE_UP = 16'sd737;
	localparam logic signed [15:0] EYE_FORWARD = 16'sd205;
	localparam logic signed [15:0] EAR_SIDE = 16'sd492;

	typedef enum logic [2:0] {
		REG_TORSO = 3'd0,
		REG_SHOULDER = 3'd1,
		REG_HIP = 3'd2,
		REG_UPPER_ARM = 3'd3,
		REG_LOWER_ARM = 3'd4,
		REG_THIGH = 3'd5,
		REG_CALF = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] c;
		logic signed [15:0] s;
	} trig_t;

	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic signed [23:0] z;
	} vec_t;

	typedef struct packed {
		logic [13:0] torso;
		logic [13:0] sho;
		logic [13:0] hip;
		logic [13:0] ua;
		logic [13:0] la;
		logic [13:0] th;
		logic [13:0] ca;
	} cfg_t;

	typedef struct packed {
		logic signed [15:0] pelvis_x;
		logic signed [15:0] pelvis_z;
		logic signed [15:0] body_yaw;
		logic signed [15:0] left_shoulder_yaw;
		logic signed [15:0] left_shoulder_pitch;
		logic signed [15:0] left_shoulder_roll;
		logic signed [15:0] right_shoulder_yaw;
		logic signed [15:0] right_shoulder_pitch;
		logic signed [15:0] right_shoulder_roll;
		logic signed [15:0] left_elbow_flex;
		logic signed [15:0] right_elbow_flex;
	} pose_t;

	typedef struct packed {
		logic [4:0] point_index;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic last_point;
	} point_t;

	typedef logic signed [31:0] atan_arr_t [CORDIC_STEPS];
	localparam atan_arr_t ATAN_TAB = '{
		32'sd210828714, 32'sd124459457, 32'sd65760959, 32'sd33381290,
		32'sd16755422, 32'sd8385879, 32'sd4193963, 32'sd2097109,
		32'sd1048571, 32'sd524287, 32'sd262144, 32'sd131072,
		32'sd65536, 32'sd32768, 32'sd16384, 32'sd8192
	};

	// round half up by 14 bits of a product sum
	function automatic logic signed [23:0] rnd14(input logic signed [41:0] v);
		logic signed [41:0] t;
		t = (v + 42'sd8192) >>> 14;
		return t[23:0];
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
		if (v > 24'sd32767) return 16'sh7fff;
		else if (v < -24'sd32768) return 16'sh8000;
		else return v[15:0];
	endfunction

	// a: rotated first component, b: second; returns c*a - s*b and s*a + c*b
	function automatic logic signed [23:0] rot_a(input trig_t t,
			input logic signed [23:0] a, input logic signed [23:0] b);
		logic signed [41:0] p;
		p = 42'(t.c * a) - 42'(t.s * b);
		return rnd14(p);
	endfunction

	function automatic logic signed [23:0] rot_b(input trig_t t,
			input logic signed [23:0] a, input logic signed [23:0] b);
		logic signed [41:0] p;
		p = 42'(t.s * a) + 42'(t.c * b);
		return rnd14(p);
	endfunction

endpackage

[rtl/sfk_if.sv]
// Interfaces: valid/ready stream channels and the configuration write channel.
interface sfk_pose_if;
	logic valid;
	logic ready;
	sfk_pkg::pose_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sfk_point_if;
	logic valid;
	logic ready;
	sfk_pkg::point_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sfk_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [15:0] wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

[rtl/sfk_cordic.sv]
// Pipelined CORDIC: sine and cosine of all pose angles, one stage per step.
module sfk_cordic (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input logic signed [15:0] ang [sfk_pkg::NUM_ANG],
	output logic out_valid,
	output sfk_pkg::trig_t trig [sfk_pkg::NUM_ANG]
);
	localparam int N = sfk_pkg::NUM_ANG;
	localparam int S = sfk_pkg::CORDIC_STEPS;

	logic signed [31:0] x_q [S+1][N];
	logic signed [31:0] y_q [S+1][N];
	logic signed [31:0] z_q [S+1][N];
	logic neg_q [S+1][N];
	logic [S:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[S-1:0], in_valid};
		end
	end

	// stage 0: range reduction
	always_ff @(posedge clk) begin
		if (en) begin
			for (int a = 0; a < N; a++) begin
				logic signed [31:0] z;
				z = 32'(ang[a]) <<< 15;
				x_q[0][a] <= sfk_pkg::CORDIC_K;
				y_q[0][a] <= '0;
				if (z > sfk_pkg::ANG_HALF_PI) begin
					z_q[0][a] <= z - sfk_pkg::ANG_PI;
					neg_q[0][a] <= 1'b1;
				end else if (z < -sfk_pkg::ANG_HALF_PI) begin
					z_q[0][a] <= z + sfk_pkg::ANG_PI;
					neg_q[0][a] <= 1'b1;
				end else begin
					z_q[0][a] <= z;
					neg_q[0][a] <= 1'b0;
				end
			end
		end
	end

	for (genvar i = 0; i < S; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (en) begin
				for (int a = 0; a < N; a++) begin
					neg_q[i+1][a] <= neg_q[i][a];
					if (!z_q[i][a][31]) begin
						x_q[i+1][a] <= x_q[i][a] - (y_q[i][a] >>> i);
						y_q[i+1][a] <= y_q[i][a] + (x_q[i][a] >>> i);
						z_q[i+1][a] <= z_q[i][a] - sfk_pkg::ATAN_TAB[i];
					end else begin
						x_q[i+1][a] <= x_q[i][a] + (y_q[i][a] >>> i);
						y_q[i+1][a] <= y_q[i][a] - (x_q[i][a] >>> i);
						z_q[i+1][a] <= z_q[i][a] + sfk_pkg::ATAN_TAB[i];
					end
				end
			end
		end
	end

	always_comb begin
		for (int a = 0; a < N; a++) begin
			logic signed [31:0] xf, yf;
			xf = neg_q[S][a] ? -x_q[S][a] : x_q[S][a];
			yf = neg_q[S][a] ? -y_q[S][a] : y_q[S][a];
			xf = (xf + 32'sd32768) >>> 16;
			yf = (yf + 32'sd32768) >>> 16;
			trig[a].c = xf[15:0];
			trig[a].s = yf[15:0];
		end
	end
	assign out_valid = vld_q[S];
endmodule

[rtl/sfk_rotate.sv]
// Rotation pipeline: shoulder, elbow and leg vectors, one axis per stage.
module sfk_rotate (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input sfk_pkg::trig_t trig [sfk_pkg::NUM_ANG],
	input sfk_pkg::cfg_t cfg,
	input logic signed [15:0] px,
	input logic signed [15:0] pz,
	output logic out_valid,
	output sfk_pkg::vec_t pts [sfk_pkg::NUM_POINTS]
);
	// angle order: 0 body, 1-3 left y/p/r, 4-6 right y/p/r, 7 left elbow, 8 right elbow
	typedef sfk_pkg::vec_t vec_t;
	sfk_pkg::trig_t t_s1 [sfk_pkg::NUM_ANG];
	sfk_pkg::trig_t t_s2 [sfk_pkg::NUM_ANG];
	sfk_pkg::trig_t t_s3 [sfk_pkg::NUM_ANG];
	// arm vectors: 0 left upper, 1 left lower, 2 right upper, 3 right lower
	vec_t a_s1 [4], a_s2 [4], a_s3 [4], a_s4 [4];
	// leg vectors: 0 right hip, 1 thigh, 2 calf, 3 left hip
	vec_t leg_s1 [4];
	vec_t leg_s2 [4], leg_s3 [4], leg_s4 [4];
	logic signed [15:0] px_s1, pz_s1, px_s2, pz_s2, px_s3, pz_s3, px_s4, pz_s4;
	sfk_pkg::cfg_t c_s1, c_s2, c_s3, c_s4;
	logic [3:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[2:0], in_valid};
	end

	// stage 1: elbow hinge and leg yaw
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [23:0] la, ua;
			la = -24'(cfg.la);
			ua = -24'(cfg.ua);
			t_s1 <= trig;
			px_s1 <= px; pz_s1 <= pz; c_s1 <= cfg;
			a_s1[0] <= '{x: '0, y: ua, z: '0};
			a_s1[2] <= '{x: '0, y: ua, z: '0};
			a_s1[1] <= '{x: '0, y: sfk_pkg::rot_a(trig[7], la, 24'sd0),
				z: sfk_pkg::rot_b(trig[7], la, 24'sd0)};
			a_s1[3] <= '{x: '0, y: sfk_pkg::rot_a(trig[8], la, 24'sd0),
				z: sfk_pkg::rot_b(trig[8], la, 24'sd0)};
			// right hip (+x), thigh, calf (-y), left hip (-x) under Ry
			leg_s1[0] <= '{x: sfk_pkg::rot_a(trig[0], 24'(cfg.hip), 24'sd0), y: '0,
				z: sfk_pkg::rot_a(trig[0], 24'sd0, 24'(cfg.hip))};
			leg_s1[1] <= '{x: '0, y: -24'(cfg.th), z: '0};
			leg_s1[2] <= '{x: '0, y: -24'(cfg.ca), z: '0};
			leg_s1[3] <= '{x: sfk_pkg::rot_a(trig[0], -24'(cfg.hip), 24'sd0), y: '0,
				z: sfk_pkg::rot_a(trig[0], 24'sd0, -24'(cfg.hip))};
		end
	end

	// stages 2-4: roll, pitch, yaw
	always_ff @(posedge clk) begin
		if (en) begin
			t_s2 <= t_s1; leg_s2 <= leg_s1; px_s2 <= px_s1; pz_s2 <= pz_s1; c_s2 <= c_s1;
			for (int k = 0; k < 4; k++) begin
				sfk_pkg::trig_t r;
				r = (k < 2) ? t_s1[3] : t_s1[6];
				a_s2[k].x <= sfk_pkg::rot_a(r, a_s1[k].x, a_s1[k].y);
				a_s2[k].y <= sfk_pkg::rot_b(r, a_s1[k].x, a_s1[k].y);
				a_s2[k].z <= a_s1[k].z;
			end
			t_s3 <= t_s2; leg_s3 <= leg_s2; px_s3 <= px_s2; pz_s3 <= pz_s2; c_s3 <= c_s2;
			for (int k = 0; k < 4; k++) begin
				sfk_pkg::trig_t p;
				p = (k < 2) ? t_s2[2] : t_s2[5];
				a_s3[k].x <= a_s2[k].x;
				a_s3[k].y <= sfk_pkg::rot_a(p, a_s2[k].y, a_s2[k].z);
				a_s3[k].z <= sfk_pkg::rot_b(p, a_s2[k].y, a_s2[k].z);
			end
			leg_s4 <= leg_s3; px_s4 <= px_s3; pz_s4 <= pz_s3; c_s4 <= c_s3;
			for (int k = 0; k < 4; k++) begin
				sfk_pkg::trig_t y;
				y = (k < 2) ? t_s3[1] : t_s3[4];
				// Ry: x' = c x + s z, z' = c z - s x
				a_s4[k].x <= sfk_pkg::rot_b(y, a_s3[k].z, a_s3[k].x);
				a_s4[k].y <= a_s3[k].y;
				a_s4[k].z <= sfk_pkg::rot_a(y, a_s3[k].z, a_s3[k].x);
			end
		end
	end

	// assemble points; the rotated leg segments of a pure -y vector stay -y
	always_comb begin
		vec_t pel, nk, ls, rs, lh, rh;
		pel = '{x: 24'(px_s4), y: '0, z: 24'(pz_s4)};
		nk = pel; nk.y = 24'(c_s4.torso);
		rs = nk; rs.x = nk.x + 24'(c_s4.sho);
		ls = nk; ls.x = nk.x - 24'(c_s4.sho);
		rh.x = pel.x + leg_s4[0].x; rh.y = '0; rh.z = pel.z + leg_s4[0].z;
		lh.x = pel.x + leg_s4[3].x; lh.y = '0; lh.z = pel.z + leg_s4[3].z;
		pts[0] = nk; pts[0].y = nk.y + 24'(sfk_pkg::NOSE_UP);
		pts[1] = nk;
		pts[2] = rs;
		pts[3] = '{x: rs.x + a_s4[2].x, y: rs.y + a_s4[2].y, z: rs.z + a_s4[2].z};
		pts[4] = '{x: pts[3].x + a_s4[3].x, y: pts[3].y + a_s4[3].y,
			z: pts[3].z + a_s4[3].z};
		pts[5] = ls;
		pts[6] = '{x: ls.x + a_s4[0].x, y: ls.y + a_s4[0].y, z: ls.z + a_s4[0].z};
		pts[7] = '{x: pts[6].x + a_s4[1].x, y: pts[6].y + a_s4[1].y,
			z: pts[6].z + a_s4[1].z};
		pts[8] = rh;
		pts[9] = rh; pts[9].y = leg_s4[1].y;
		pts[10] = rh; pts[10].y = leg_s4[1].y + leg_s4[2].y;
		pts[11] = lh;
		pts[12] = lh; pts[12].y = leg_s4[1].y;
		pts[13] = lh; pts[13].y = leg_s4[1].y + leg_s4[2].y;
		pts[14] = '{x: nk.x + 24'(sfk_pkg::EYE_SIDE), y: nk.y + 24'(sfk_pkg::EYE_UP),
			z: nk.z + 24'(sfk_pkg::EYE_FORWARD)};
		pts[15] = '{x: nk.x - 24'(sfk_pkg::EYE_SIDE), y: nk.y + 24'(sfk_pkg::EYE_UP),
			z: nk.z + 24'(sfk_pkg::EYE_FORWARD)};
		pts[16] = '{x: nk.x + 24'(sfk_pkg::EAR_SIDE), y: nk.y + 24'(sfk_pkg::NOSE_UP),
			z: nk.z};
		pts[17] = '{x: nk.x - 24'(sfk_pkg::EAR_SIDE), y: nk.y + 24'(sfk_pkg::NOSE_UP),
			z: nk.z};
	end
	assign out_valid = vld_q[3];
endmodule

[rtl/skeleton_forward_kinematics.sv]
// Top level: pose in, eighteen keypoints out through a serializer.
// A pose flows through a 17-stage CORDIC for all nine angles and a 4-stage
// rotation pipeline (elbow/leg yaw, roll, pitch, shoulder yaw), then a
// serializer emits its 18 keypoints one per cycle while the sink is ready.
// The serializer sets the pose rate, but the pipeline takes new poses while
// earlier ones are still being emitted. An output stall freezes the whole
// pipeline once a finished pose waits for the serializer. Configuration
// writes take effect for poses accepted afterward.
module skeleton_forward_kinematics (
	input logic clk,
	input logic arst_n,
	sfk_cfg_if.sink cfg,
	sfk_pose_if.sink pose,
	sfk_point_if.source point
);
	sfk_pkg::cfg_t cfg_q;
	logic signed [15:0] ang [sfk_pkg::NUM_ANG];
	sfk_pkg::trig_t trig [sfk_pkg::NUM_ANG];
	sfk_pkg::vec_t pts [sfk_pkg::NUM_POINTS];
	sfk_pkg::vec_t buf_q [sfk_pkg::NUM_POINTS];
	logic cv, rv, en, busy_q, load;
	logic [4:0] idx_q;
	logic signed [15:0] px_d [17], pz_d [17];
	sfk_pkg::cfg_t cd [17];

	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{torso: 14'd2048, sho: 14'd819, hip: 14'd614, ua: 14'd1374,
				la: 14'd1194, th: 14'd1638, ca: 14'd2048};
		end else if (cfg.valid) begin
			case (cfg.index)
				sfk_pkg::REG_TORSO: cfg_q.torso <= cfg.wdata[13:0];
				sfk_pkg::REG_SHOULDER: cfg_q.sho <= cfg.wdata[13:0];
				sfk_pkg::REG_HIP: cfg_q.hip <= cfg.wdata[13:0];
				sfk_pkg::REG_UPPER_ARM: cfg_q.ua <= cfg.wdata[13:0];
				sfk_pkg::REG_LOWER_ARM: cfg_q.la <= cfg.wdata[13:0];
				sfk_pkg::REG_THIGH: cfg_q.th <= cfg.wdata[13:0];
				sfk_pkg::REG_CALF: cfg_q.ca <= cfg.wdata[13:0];
				default: ;
			endcase
		end
	end

	assign ang = '{pose.data.body_yaw, pose.data.left_shoulder_yaw,
		pose.data.left_shoulder_pitch, pose.data.left_shoulder_roll,
		pose.data.right_shoulder_yaw, pose.data.right_shoulder_pitch,
		pose.data.right_shoulder_roll, pose.data.left_elbow_flex,
		pose.data.right_elbow_flex};

	// advance when the serializer can take a finished pose
	assign load = rv && (!busy_q || (point.ready && idx_q == 5'd17));
	assign en = !rv || load;
	assign pose.ready = en;

	// carry pelvis and lengths alongside the CORDIC
	always_ff @(posedge clk) begin
		if (en) begin
			px_d[0] <= pose.data.pelvis_x; pz_d[0] <= pose.data.pelvis_z; cd[0] <= cfg_q;
			for (int i = 1; i < 17; i++) begin
				px_d[i] <= px_d[i-1]; pz_d[i] <= pz_d[i-1]; cd[i] <= cd[i-1];
			end
		end
	end

	sfk_cordic u_cordic (.clk, .arst_n, .en, .in_valid(pose.valid), .ang,
		.out_valid(cv), .trig);

	sfk_rotate u_rotate (.clk, .arst_n, .en, .in_valid(cv), .trig, .cfg(cd[16]),
		.px(px_d[16]), .pz(pz_d[16]), .out_valid(rv), .pts);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			idx_q <= '0;
		end else if (busy_q && point.ready) begin
			if (idx_q == 5'd17) busy_q <= 1'b0;
			else idx_q <= idx_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) buf_q <= pts;
	end

	assign point.valid = busy_q;
	assign point.data.point_index = idx_q;
	assign point.data.pos_x = sfk_pkg::sat16(buf_q[idx_q].x);
	assign point.data.pos_y = sfk_pkg::sat16(buf_q[idx_q].y);
	assign point.data.pos_z = sfk_pkg::sat16(buf_q[idx_q].z);
	assign point.data.last_point = (idx_q == 5'd17);

	a_idx: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q <= 5'd17) else $error("index past last point");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && !point.ready |=> $stable(idx_q)) else $error("index moved on stall");
	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && idx_q == 5'd0) else $error("load did not restart");
endmodule

[bench/sfk_tb_pkg.sv]
// Scoreboard class and keypoint predictor for the skeleton kinematics bench.
`timescale 1ns / 1ps
package sfk_tb_pkg;
	import sfk_pkg::*;

	typedef struct {
		longint c;
		longint s;
	} sc_t;

	typedef struct {
		longint x;
		longint y;
		longint z;
	} v3_t;

	localparam longint ATAN_STEP [16] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879, 4193963,
		2097109, 1048571, 524287, 262144, 131072, 65536, 32768, 16384, 8192
	};

	function automatic longint fshr(longint v, int n);
		if (v >= 0) return v >>> n;
		return -(((-v) + ((64'sd1 <<< n) - 1)) >>> n);
	endfunction

	function automatic longint rshr(longint v, int n);
		return fshr(v + (64'sd1 <<< (n - 1)), n);
	endfunction

	function automatic sc_t angle_trig(logic signed [15:0] a);
		longint z, x, y, nx;
		bit neg;
		sc_t t;
		z = longint'(a) * 32768;
		x = 652032874;
		y = 0;
		neg = 0;
		if (z > 421657428) begin
			z -= 843314857;
			neg = 1;
		end else if (z < -421657428) begin
			z += 843314857;
			neg = 1;
		end
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - fshr(y, i);
				y = y + fshr(x, i);
				z -= ATAN_STEP[i];
			end else begin
				nx = x + fshr(y, i);
				y = y - fshr(x, i);
				z += ATAN_STEP[i];
			end
			x = nx;
		end
		if (neg) begin
			x = -x;
			y = -y;
		end
		t.c = rshr(x, 16);
		t.s = rshr(y, 16);
		return t;
	endfunction

	function automatic v3_t v3(longint x, longint y, longint z);
		v3_t v;
		v.x = x;
		v.y = y;
		v.z = z;
		return v;
	endfunction

	function automatic v3_t vsum(v3_t a, v3_t b);
		return v3(a.x + b.x, a.y + b.y, a.z + b.z);
	endfunction

	function automatic v3_t turn_x(v3_t v, sc_t t);
		return v3(v.x, rshr(t.c * v.y - t.s * v.z, 14), rshr(t.s * v.y + t.c * v.z, 14));
	endfunction

	function automatic v3_t turn_y(v3_t v, sc_t t);
		return v3(rshr(t.c * v.x + t.s * v.z, 14), v.y, rshr(t.c * v.z - t.s * v.x, 14));
	endfunction

	function automatic v3_t turn_z(v3_t v, sc_t t);
		return v3(rshr(t.c * v.x - t.s * v.y, 14), rshr(t.s * v.x + t.c * v.y, 14), v.z);
	endfunction

	function automatic v3_t arm_turn(v3_t v, sc_t yw, sc_t pt, sc_t rl);
		return turn_y(turn_x(turn_z(v, rl), pt), yw);
	endfunction

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767) return 16'sh7fff;
		if (v < -32768) return 16'sh8000;
		return v[15:0];
	endfunction

	class keypoint_board;
		logic [13:0] lens [7];
		point_t pending [$];
		bit failed;

		function new();
			lens = '{2048, 819, 614, 1374, 1194, 1638, 2048};
			failed = 0;
		endfunction

		function void write_len(logic [2:0] idx, logic [15:0] val);
			if (idx <= REG_CALF) lens[idx] = val[13:0];
		endfunction

		function void note_pose(pose_t p);
			sc_t tb, ly, lp, lr, ry, rp, rr, le, re;
			v3_t pt [18];
			v3_t pel, nk, up, lo, thv, cav;
			point_t r;
			tb = angle_trig(p.body_yaw);
			ly = angle_trig(p.left_shoulder_yaw);
			lp = angle_trig(p.left_shoulder_pitch);
			lr = angle_trig(p.left_shoulder_roll);
			ry = angle_trig(p.right_shoulder_yaw);
			rp = angle_trig(p.right_shoulder_pitch);
			rr = angle_trig(p.right_shoulder_roll);
			le = angle_trig(p.left_elbow_flex);
			re = angle_trig(p.right_elbow_flex);
			pel = v3(p.pelvis_x, 0, p.pelvis_z);
			nk = vsum(pel, v3(0, lens[REG_TORSO], 0));
			up = v3(0, -longint'(lens[REG_UPPER_ARM]), 0);
			lo = v3(0, -longint'(lens[REG_LOWER_ARM]), 0);
			thv = turn_y(v3(0, -longint'(lens[REG_THIGH]), 0), tb);
			cav = turn_y(v3(0, -longint'(lens[REG_CALF]), 0), tb);
			pt[0] = vsum(nk, v3(0, NOSE_UP, 0));
			pt[1] = nk;
			pt[2] = vsum(nk, v3(lens[REG_SHOULDER], 0, 0));
			pt[3] = vsum(pt[2], arm_turn(up, ry, rp, rr));
			pt[4] = vsum(pt[3], arm_turn(turn_x(lo, re), ry, rp, rr));
			pt[5] = vsum(nk, v3(-longint'(lens[REG_SHOULDER]), 0, 0));
			pt[6] = vsum(pt[5], arm_turn(up, ly, lp, lr));
			pt[7] = vsum(pt[6], arm_turn(turn_x(lo, le), ly, lp, lr));
			pt[8] = vsum(pel, turn_y(v3(lens[REG_HIP], 0, 0), tb));
			pt[9] = vsum(pt[8], thv);
			pt[10] = vsum(pt[9], cav);
			pt[11] = vsum(pel, turn_y(v3(-longint'(lens[REG_HIP]), 0, 0), tb));
			pt[12] = vsum(pt[11], thv);
			pt[13] = vsum(pt[12], cav);
			pt[14] = vsum(nk, v3(EYE_SIDE, EYE_UP, EYE_FORWARD));
			pt[15] = vsum(nk, v3(-EYE_SIDE, EYE_UP, EYE_FORWARD));
			pt[16] = vsum(nk, v3(EAR_SIDE, NOSE_UP, 0));
			pt[17] = vsum(nk, v3(-EAR_SIDE, NOSE_UP, 0));
			for (int k = 0; k < 18; k++) begin
				r.point_index = k;
				r.pos_x = clip16(pt[k].x);
				r.pos_y = clip16(pt[k].y);
				r.pos_z = clip16(pt[k].z);
				r.last_point = (k == 17);
				pending.push_back(r);
			end
		endfunction

		function void check_point(point_t got);
			point_t w;
			if (pending.size() == 0) begin
				$display("%0t: unexpected keypoint %p", $realtime, got);
				failed = 1;
				return;
			end
			w = pending.pop_front();
			if (got.point_index !== w.point_index) begin
				$display("%0t: point_index exp %0d got %0d", $realtime, w.point_index,
					got.point_index);
				failed = 1;
			end
			if (got.pos_x !== w.pos_x) begin
				$display("%0t: pos_x[%0d] exp %0d got %0d", $realtime, w.point_index,
					w.pos_x, got.pos_x);
				failed = 1;
			end
			if (got.pos_y !== w.pos_y) begin
				$display("%0t: pos_y[%0d] exp %0d got %0d", $realtime, w.point_index,
					w.pos_y, got.pos_y);
				failed = 1;
			end
			if (got.pos_z !== w.pos_z) begin
				$display("%0t: pos_z[%0d] exp %0d got %0d", $realtime, w.point_index,
					w.pos_z, got.pos_z);
				failed = 1;
			end
			if (got.last_point !== w.last_point) begin
				$display("%0t: last_point[%0d] exp %0b got %0b", $realtime, w.point_index,
					w.last_point, got.last_point);
				failed = 1;
			end
		endfunction
	endclass
endpackage

[bench/skeleton_forward_kinematics_tb.sv]
// Testbench top: drives poses and length writes, checks every keypoint.
`timescale 1ns / 1ps
module skeleton_forward_kinematics_tb;
	import sfk_pkg::*;
	import sfk_tb_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	longint cycles = 0;
	bit hold_sink = 0;
	keypoint_board board = new();

	sfk_cfg_if cfg_ch();
	sfk_pose_if pose_ch();
	sfk_point_if point_ch();

	skeleton_forward_kinematics DUT (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_ch.sink), .pose(pose_ch.sink),
		.point(point_ch.source)
	);

	always #5 clk = ~clk;

	initial begin
		cfg_ch.valid = 0;
		cfg_ch.index = 0;
		cfg_ch.wdata = 0;
		pose_ch.valid = 0;
		pose_ch.data = '0;
		point_ch.ready = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("skeleton_forward_kinematics_tb: FAIL");
			$finish;
		end
	end

	// sink: random stalls, plus one long hold-off while the source keeps offering
	always @(posedge clk) begin
		if (arst_n && point_ch.valid && point_ch.ready) board.check_point(point_ch.data);
	end

	initial begin
		int w;
		@(posedge arst_n);
		forever begin
			if (hold_sink) begin
				point_ch.ready <= 0;
				repeat (300) @(posedge clk);
				hold_sink = 0;
			end
			w = $urandom_range(0, 6);
			if ($urandom_range(0, 3) == 0) w = 0;
			point_ch.ready <= (w == 0);
			if (w != 0) begin
				repeat (w) @(posedge clk);
				point_ch.ready <= 1;
			end
			@(posedge clk);
		end
	end

	task automatic write_len(logic [2:0] idx, logic [15:0] val);
		cfg_ch.valid <= 1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		board.write_len(idx, val);
		cfg_ch.valid <= 0;
		@(posedge clk);
	endtask

	// valid stays high into the next item when it follows with no gap
	task automatic send_pose(pose_t p, bit gaps);
		int w;
		w = gaps ? $urandom_range(0, 6) : 0;
		if (w != 0) begin
			pose_ch.valid <= 0;
			repeat (w) @(posedge clk);
		end
		pose_ch.valid <= 1;
		pose_ch.data <= p;
		do @(posedge clk); while (!pose_ch.ready);
		board.note_pose(p);
	endtask

	task automatic drain();
		pose_ch.valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	function automatic logic signed [15:0] rand_angle();
		if ($urandom_range(0, 9) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 51472) - 25736);
	endfunction

	function automatic pose_t rand_pose();
		pose_t p;
		p.pelvis_x = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 16383) - 8192);
		p.pelvis_z = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
			16'($urandom_range(0, 16383) - 8192);
		p.body_yaw = rand_angle();
		p.left_shoulder_yaw = rand_angle();
		p.left_shoulder_pitch = rand_angle();
		p.left_shoulder_roll = rand_angle();
		p.right_shoulder_yaw = rand_angle();
		p.right_shoulder_pitch = rand_angle();
		p.right_shoulder_roll = rand_angle();
		p.left_elbow_flex = rand_angle();
		p.right_elbow_flex = rand_angle();
		return p;
	endfunction

	function automatic pose_t flat_pose(logic signed [15:0] px, logic signed [15:0] pz,
			logic signed [15:0] a);
		pose_t p;
		p.pelvis_x = px;
		p.pelvis_z = pz;
		p.body_yaw = a;
		p.left_shoulder_yaw = a;
		p.left_shoulder_pitch = a;
		p.left_shoulder_roll = a;
		p.right_shoulder_yaw = a;
		p.right_shoulder_pitch = a;
		p.right_shoulder_roll = a;
		p.left_elbow_flex = a;
		p.right_elbow_flex = a;
		return p;
	endfunction

	initial begin
		logic signed [15:0] corner [10];
		corner = '{0, 25736, -25736, 12868, -12868, 32767, -32768, 1, -1, 12869};
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: default lengths, angle extremes and saturating positions, then random poses
		foreach (corner[i]) send_pose(flat_pose(0, 0, corner[i]), 0);
		send_pose(flat_pose(16'sh7fff, 16'sh7fff, 0), 0);
		send_pose(flat_pose(16'sh8000, 16'sh8000, 25736), 0);
		send_pose(flat_pose(16'sh7000, -16'sh7000, -25736), 0);
		for (int i = 0; i < 5; i++) send_pose(rand_pose(), 1);
		drain();

		// largest lengths, plus an ignored register index
		for (int r = REG_TORSO; r <= REG_CALF; r++) write_len(3'(r), 16'hffff);
		write_len(3'd7, 16'h0000);
		send_pose(flat_pose(16'sh7fff, 0, 0), 0);
		send_pose(flat_pose(16'sh8000, 16'sh8000, -32768), 0);
		for (int i = 0; i < 30; i++) send_pose(rand_pose(), 1);
		drain();

		// zero lengths
		for (int r = REG_TORSO; r <= REG_CALF; r++) write_len(3'(r), 16'h0000);
		send_pose(flat_pose(0, 0, 12868), 0);
		for (int i = 0; i < 30; i++) send_pose(rand_pose(), 1);
		drain();

		// random lengths, with one long sink hold-off
		for (int r = REG_TORSO; r <= REG_CALF; r++) write_len(3'(r), 16'($urandom));
		hold_sink = 1;
		for (int i = 0; i < 40; i++) send_pose(rand_pose(), i > 10);
		drain();

		for (int r = REG_TORSO; r <= REG_CALF; r++)
			write_len(3'(r), 16'($urandom_range(0, 4095)));
		for (int i = 0; i < 40; i++) send_pose(rand_pose(), 1'($urandom_range(0, 1)));
		drain();

		if (!board.failed && board.pending.size() == 0)
			$display("skeleton_forward_kinematics_tb: PASS");
		else
			$display("skeleton_forward_kinematics_tb: FAIL");
		$finish;
	end
endmodule
